[design/slc_pkg.sv]
// ---------------------------------------------------------------------------
// slc_pkg
// Shared sizes, codes and structs of the sector cache tag engine.
// ---------------------------------------------------------------------------
`default_nettype none

package slc_pkg;

  localparam int ENTRIES   = 128;
  localparam int MAX_DISKS = 4;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int SLOT_W    = 7;
  localparam int OP_W      = 2;
  localparam int DISK_W    = 2;
  localparam int LBA_W     = 48;
  localparam int AGE_W     = 32;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_FILL   = 2'd1,
    OP_UPDATE = 2'd2,
    OP_INVAL  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } state_t;

  // running search record handed from cell to cell
  typedef struct packed {
    logic             active;
    logic             hit_found;
    logic [IDX_W-1:0] hit_idx;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             min_found;
    logic [IDX_W-1:0] min_idx;
    logic [AGE_W-1:0] min_age;
  } scan_tok_t;

  // update broadcast to every cell at the end of a scan
  typedef struct packed {
    logic              en;
    logic              touch;
    logic              wr;
    logic [IDX_W-1:0]  idx;
    logic [DISK_W-1:0] disk;
    logic [LBA_W-1:0]  lba;
    logic [AGE_W-1:0]  age;
    logic              inv;
    logic              inv_all;
    logic [DISK_W-1:0] inv_disk;
  } cell_cmd_t;

endpackage

`default_nettype wire

[design/slc_if.sv]
// ---------------------------------------------------------------------------
// slc_in_if / slc_out_if
// Valid/ready channels carrying the request word and the response word.
// ---------------------------------------------------------------------------
`default_nettype none

interface slc_in_if import slc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [DISK_W-1:0] disk;
  logic [LBA_W-1:0]  lba;
  logic              all_disks;

  modport source (output valid, opcode, disk, lba, all_disks, input ready);
  modport sink   (input valid, opcode, disk, lba, all_disks, output ready);
endinterface

interface slc_out_if import slc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic              slot_valid;
  logic              evicted;

  modport source (output valid, hit, slot, slot_valid, evicted, input ready);
  modport sink   (input valid, hit, slot, slot_valid, evicted, output ready);
endinterface

`default_nettype wire

[design/slc_cell.sv]
// ---------------------------------------------------------------------------
// slc_cell
// One cache entry: holds key, age and valid, and folds itself into the
// search record passing through on its way down the chain.
// ---------------------------------------------------------------------------
`default_nettype none

module slc_cell import slc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [IDX_W-1:0]  idx,
  input  wire logic [DISK_W-1:0] qry_disk,
  input  wire logic [LBA_W-1:0]  qry_lba,
  input  wire cell_cmd_t         cmd,
  input  wire scan_tok_t         tok_in,
  output scan_tok_t              tok_out
);

  logic              valid;
  logic [DISK_W-1:0] disk;
  logic [LBA_W-1:0]  lba;
  logic [AGE_W-1:0]  age;
  logic              match;
  logic              sel;
  scan_tok_t         tok_next;

  assign sel = cmd.en && (cmd.idx == idx);

  always_comb begin
    match    = valid && (disk == qry_disk) && (lba == qry_lba);
    tok_next = tok_in;
    if (tok_in.active) begin
      if (match && !tok_in.hit_found) begin
        tok_next.hit_found = 1'b1;
        tok_next.hit_idx   = idx;
      end
      if (!valid && !tok_in.free_found) begin
        tok_next.free_found = 1'b1;
        tok_next.free_idx   = idx;
      end
      // strict compare keeps the lowest index on equal ages
      if (valid && (!tok_in.min_found || (age < tok_in.min_age))) begin
        tok_next.min_found = 1'b1;
        tok_next.min_idx   = idx;
        tok_next.min_age   = age;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sel && cmd.wr) begin
      valid <= 1'b1;
    end else if (cmd.en && cmd.inv && (cmd.inv_all || (disk == cmd.inv_disk))) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.wr) begin
      disk <= cmd.disk;
      lba  <= cmd.lba;
    end
    if (sel && cmd.touch) begin
      age <= cmd.age;
    end
  end

endmodule

`default_nettype wire

[design/slc_chain.sv]
// ---------------------------------------------------------------------------
// slc_chain
// Row of entry cells; a search record enters at cell 0 and steps one cell
// per cycle, leaving the tail with the hit, first free and oldest entry.
// ---------------------------------------------------------------------------
`default_nettype none

module slc_chain import slc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DISK_W-1:0] qry_disk,
  input  wire logic [LBA_W-1:0]  qry_lba,
  input  wire cell_cmd_t         cmd,
  output scan_tok_t              tail
);

  scan_tok_t tok [ENTRIES+1];

  always_comb begin
    tok[0]        = '0;
    tok[0].active = start;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    slc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (IDX_W'(i)),
      .qry_disk (qry_disk),
      .qry_lba  (qry_lba),
      .cmd      (cmd),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  assign tail = tok[ENTRIES];

endmodule

`default_nettype wire

[design/sector_cache_lru_tags.sv]
// ---------------------------------------------------------------------------
// sector_cache_lru_tags
// Tag and least-recently-used replacement engine of a fully associative
// disk-sector cache keyed by (disk, lba).
// ---------------------------------------------------------------------------
// Usage:
//   req carries one request word (opcode, disk, lba, all_disks); rsp returns
//   exactly one response word (hit, slot, slot_valid, evicted) per request.
//   Requests are taken one at a time: req.ready is high only while the
//   engine is idle. After acceptance the search record walks the entry
//   chain one cell per cycle; the result is then registered and loaded into
//   the output register, and a new request may follow once the engine is
//   back in idle, a return that waits while rsp stalls a held word.
//   The entry update (age stamp, allocation or invalidation) is broadcast to
//   all cells at once, from a register loaded at the end of the walk.
//   The response sits in an output register; while rsp.ready is low the
//   finished word holds, and the next request's result waits until that
//   register frees, with req.ready low meanwhile.
//   Reset (rst, synchronous) frees every entry at once and clears the use
//   clock; the engine is ready as soon as reset is released.
// ---------------------------------------------------------------------------
`default_nettype none

module sector_cache_lru_tags import slc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  slc_in_if.sink     req,
  slc_out_if.source  rsp
);

  state_t            state;
  state_t            state_next;
  logic              accept;
  logic              start;
  logic              load_out;
  logic              scan_done;

  op_t               q_op;
  logic [DISK_W-1:0] q_disk;
  logic [LBA_W-1:0]  q_lba;
  logic              q_all;
  logic [AGE_W-1:0]  use_clock;

  scan_tok_t         tail;
  cell_cmd_t         cmd;
  cell_cmd_t         cmd_next;

  logic              key_ok;
  logic              is_inv;
  logic              d_hit;
  logic              d_alloc;
  logic [IDX_W-1:0]  victim;
  logic [IDX_W-1:0]  d_idx;

  logic              res_hit;
  logic [IDX_W-1:0]  res_idx;
  logic              res_sv;
  logic              res_ev;

  logic              out_valid;
  logic              out_hit;
  logic [SLOT_W-1:0] out_slot;
  logic              out_sv;
  logic              out_ev;

  // control
  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    load_out   = 1'b0;
    scan_done  = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail.active) begin
          scan_done  = 1'b1;
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign accept = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // decision from the record leaving the tail
  always_comb begin
    key_ok  = int'(q_disk) < MAX_DISKS;
    is_inv  = (q_op == OP_INVAL);
    d_hit   = !is_inv && key_ok && tail.hit_found;
    d_alloc = !is_inv && key_ok && !tail.hit_found && (q_op == OP_FILL);
    victim  = tail.free_found ? tail.free_idx : tail.min_idx;
    d_idx   = d_hit ? tail.hit_idx : (d_alloc ? victim : '0);

    cmd_next          = '0;
    cmd_next.en       = scan_done;
    cmd_next.touch    = d_hit || d_alloc;
    cmd_next.wr       = d_alloc;
    cmd_next.idx      = d_idx;
    cmd_next.disk     = q_disk;
    cmd_next.lba      = q_lba;
    cmd_next.age      = use_clock + AGE_W'(1);
    cmd_next.inv      = is_inv && (q_all || key_ok);
    cmd_next.inv_all  = q_all;
    cmd_next.inv_disk = q_disk;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start     <= 1'b0;
      cmd       <= '0;
      use_clock <= '0;
    end else begin
      start <= accept;
      cmd   <= cmd_next;
      if (scan_done && (d_hit || d_alloc)) begin
        use_clock <= use_clock + AGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_op   <= op_t'(req.opcode);
      q_disk <= req.disk;
      q_lba  <= req.lba;
      q_all  <= req.all_disks;
    end
    if (scan_done) begin
      res_hit <= d_hit;
      res_idx <= d_idx;
      res_sv  <= d_hit || d_alloc;
      res_ev  <= d_alloc && !tail.free_found;
    end
    if (load_out) begin
      out_hit  <= res_hit;
      out_slot <= SLOT_W'(res_idx);
      out_sv   <= res_sv;
      out_ev   <= res_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.hit        = out_hit;
  assign rsp.slot       = out_slot;
  assign rsp.slot_valid = out_sv;
  assign rsp.evicted    = out_ev;

  slc_chain u_chain (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .qry_disk (q_disk),
    .qry_lba  (q_lba),
    .cmd      (cmd),
    .tail     (tail)
  );

endmodule

`default_nettype wire

[design/slc_chk.sv]
// ---------------------------------------------------------------------------
// slc_chk
// Port-level checks of the sector cache tag engine, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module slc_chk import slc_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              hit,
  input wire logic [SLOT_W-1:0] slot,
  input wire logic              slot_valid,
  input wire logic              evicted
);

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !slot_valid) |-> (slot == '0 && !hit && !evicted))
    else $error("slot data without a valid slot");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> !evicted)
    else $error("hit reported together with eviction");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(hit) && $stable(slot) && $stable(slot_valid)
       && $stable(evicted)))
    else $error("stalled response word changed");

endmodule

bind sector_cache_lru_tags slc_chk u_slc_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (req.valid),
  .in_ready   (req.ready),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .hit        (rsp.hit),
  .slot       (rsp.slot),
  .slot_valid (rsp.slot_valid),
  .evicted    (rsp.evicted)
);

`default_nettype wire

[tb/slc_checker.sv]
// ---------------------------------------------------------------------------
// slc_checker
// Watches the request and response channels of the sector cache tag engine.
// For every accepted request word it predicts the response from its own copy
// of the tags, ages and use clock, then checks the response words in order.
// ---------------------------------------------------------------------------
`default_nettype none

module slc_checker import slc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  slc_in_if         req,
  slc_out_if        rsp,
  output int        mismatches,
  output int        outstanding
);

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              slot_valid;
    logic              evicted;
  } tag_result_t;

  logic              line_valid [ENTRIES];
  logic [DISK_W-1:0] line_disk  [ENTRIES];
  logic [LBA_W-1:0]  line_lba   [ENTRIES];
  logic [AGE_W-1:0]  line_age   [ENTRIES];
  logic [AGE_W-1:0]  use_clock;

  tag_result_t outcome_q[$];
  int          err_cnt;
  int          rsp_cnt;

  // applies one request word to the shadow tags and returns its response
  function automatic tag_result_t tag_access(op_t op, logic [DISK_W-1:0] disk,
                                             logic [LBA_W-1:0] lba, logic all);
    tag_result_t r;
    int          found;
    int          free_idx;
    int          oldest;
    int          victim;
    r = '0;
    found = -1;
    if (op == OP_INVAL) begin
      for (int k = 0; k < ENTRIES; k++) begin
        if (all || (disk < MAX_DISKS && line_disk[k] == disk)) line_valid[k] = 1'b0;
      end
    end else if (disk < MAX_DISKS) begin
      for (int k = 0; k < ENTRIES; k++) begin
        if (found < 0 && line_valid[k] && line_disk[k] == disk && line_lba[k] == lba)
          found = k;
      end
      if (found >= 0) begin
        use_clock = use_clock + 1'b1;
        line_age[found] = use_clock;
        r.hit = 1'b1;
        r.slot = SLOT_W'(found);
        r.slot_valid = 1'b1;
      end else if (op == OP_FILL) begin
        // first free entry wins; otherwise oldest age, lowest index on a tie
        free_idx = -1;
        oldest = 0;
        for (int k = 0; k < ENTRIES; k++) begin
          if (free_idx < 0) begin
            if (!line_valid[k]) free_idx = k;
            else if (line_age[k] < line_age[oldest]) oldest = k;
          end
        end
        victim = (free_idx >= 0) ? free_idx : oldest;
        r.evicted = (free_idx < 0);
        use_clock = use_clock + 1'b1;
        line_valid[victim] = 1'b1;
        line_disk[victim] = disk;
        line_lba[victim] = lba;
        line_age[victim] = use_clock;
        r.slot = SLOT_W'(victim);
        r.slot_valid = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    tag_result_t got;
    tag_result_t want;
    if (rst) begin
      for (int k = 0; k < ENTRIES; k++) begin
        line_valid[k] = 1'b0;
        line_disk[k] = '0;
        line_lba[k] = '0;
        line_age[k] = '0;
      end
      use_clock = '0;
      outcome_q.delete();
      err_cnt = 0;
      rsp_cnt = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.hit, rsp.slot, rsp.slot_valid, rsp.evicted};
        if (outcome_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("[%0t] response word %0d arrived with no request pending: hit=%b slot=%0d slot_valid=%b evicted=%b",
                     $time, rsp_cnt, got.hit, got.slot, got.slot_valid, got.evicted);
        end else begin
          want = outcome_q.pop_front();
          if (got.hit !== want.hit || got.slot !== want.slot ||
              got.slot_valid !== want.slot_valid || got.evicted !== want.evicted) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("[%0t] response word %0d: expected hit=%b slot=%0d slot_valid=%b evicted=%b, got hit=%b slot=%0d slot_valid=%b evicted=%b",
                       $time, rsp_cnt, want.hit, want.slot, want.slot_valid, want.evicted,
                       got.hit, got.slot, got.slot_valid, got.evicted);
          end
        end
        rsp_cnt++;
      end
      if (req.valid && req.ready)
        outcome_q.push_back(tag_access(op_t'(req.opcode), req.disk, req.lba, req.all_disks));
    end
    mismatches <= err_cnt;
    outstanding <= outcome_q.size();
  end

endmodule

`default_nettype wire

[tb/tb.sv]
// ---------------------------------------------------------------------------
// tb
// Drives the sector cache tag engine with a short directed sequence and then
// a long random run over a pool of keys that overflows the cache, so that
// hits, allocations, least-recent evictions and invalidations all occur.
// Both channels idle at random; the checker predicts and compares responses.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
  import slc_pkg::*;

  localparam int RANDOM_ITEMS = 1235;
  localparam int QUIET_TAIL   = 150;
  localparam int PHASE        = 400;
  localparam int INVAL_WINDOW = 60;
  localparam int POOL         = 160;
  localparam int DRAIN_CYCLES = 2 * ENTRIES + 20;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam logic [LBA_W-1:0] LBA_MAX = '1;

  logic clk = 1'b0;
  logic rst;
  int   mismatches;
  int   outstanding;
  int   cycle_cnt;
  bit   idling_on = 1'b1;

  logic [DISK_W-1:0] pool_disk [POOL];
  logic [LBA_W-1:0]  pool_lba  [POOL];

  slc_in_if  req ();
  slc_out_if rsp ();

  sector_cache_lru_tags uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  slc_checker chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // optional idle burst, then one request word held until accepted
  task automatic send_word(input op_t op, input logic [DISK_W-1:0] disk,
                           input logic [LBA_W-1:0] lba, input logic all);
    if (idling_on && $urandom_range(0, 2) == 0) begin
      req.valid <= 1'b0;
      // sometimes let the gap land after the engine has gone idle
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk); while (!req.ready);
      end
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.opcode    <= op;
    req.disk      <= disk;
    req.lba       <= lba;
    req.all_disks <= all;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // response side stalls
  initial begin
    int stall_left;
    stall_left = 0;
    rsp.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (stall_left == 0 && idling_on && $urandom_range(0, 24) == 0)
        stall_left = $urandom_range(1, 14);
      if (stall_left != 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int                phase_pos;
    int                roll;
    int                pick;
    op_t               op;
    logic [DISK_W-1:0] disk;
    logic [LBA_W-1:0]  lba;
    logic              all;

    rst           <= 1'b1;
    req.valid     <= 1'b0;
    req.opcode    <= OP_LOOKUP;
    req.disk      <= '0;
    req.lba       <= '0;
    req.all_disks <= 1'b0;

    for (int k = 0; k < POOL; k++) begin
      pool_disk[k] = DISK_W'($urandom_range(0, MAX_DISKS - 1));
      pool_lba[k]  = LBA_W'({$urandom(), $urandom()});
    end
    pool_lba[0] = '0;
    pool_lba[1] = LBA_MAX;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: misses on an empty cache, hits, key made of both fields,
    // invalidate of one disk reusing the first free entry, invalidate all
    send_word(OP_LOOKUP, 2'd0, '0, 1'b0);
    send_word(OP_UPDATE, 2'd0, '0, 1'b0);
    send_word(OP_FILL,   2'd0, '0, 1'b0);
    send_word(OP_FILL,   2'd3, LBA_MAX, 1'b0);
    send_word(OP_LOOKUP, 2'd3, LBA_MAX, 1'b0);
    send_word(OP_LOOKUP, 2'd0, LBA_MAX, 1'b0);
    send_word(OP_UPDATE, 2'd0, '0, 1'b0);
    send_word(OP_FILL,   2'd0, '0, 1'b0);
    send_word(OP_FILL,   2'd1, 48'h5555_5555_5555, 1'b1);
    send_word(OP_FILL,   2'd2, 48'hAAAA_AAAA_AAAA, 1'b0);
    send_word(OP_INVAL,  2'd3, 48'h0123_4567_89AB, 1'b0);
    send_word(OP_LOOKUP, 2'd3, LBA_MAX, 1'b0);
    send_word(OP_FILL,   2'd2, 48'h0000_0000_0001, 1'b0);
    send_word(OP_UPDATE, 2'd2, 48'h0000_0000_0001, 1'b1);
    send_word(OP_INVAL,  2'd0, LBA_MAX, 1'b1);
    send_word(OP_LOOKUP, 2'd1, 48'h5555_5555_5555, 1'b0);
    send_word(OP_FILL,   2'd1, 48'h5555_5555_5555, 1'b0);
    wait_drained();

    // random: fill the cache past capacity, invalidate only near phase ends
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      phase_pos = i % PHASE;
      idling_on = !(i >= RANDOM_ITEMS - QUIET_TAIL || (i / 100) % 4 == 3);
      if (phase_pos == 0 && i != 0) wait_drained();
      roll = $urandom_range(0, 99);
      if (phase_pos < PHASE - INVAL_WINDOW)
        op = (roll < 60) ? OP_FILL : (roll < 82) ? OP_LOOKUP : OP_UPDATE;
      else
        op = (roll < 30) ? OP_FILL : (roll < 50) ? OP_LOOKUP :
             (roll < 70) ? OP_UPDATE : OP_INVAL;
      if ($urandom_range(0, 99) < 85) begin
        pick = $urandom_range(0, POOL - 1);
        disk = pool_disk[pick];
        lba  = pool_lba[pick];
      end else begin
        disk = DISK_W'($urandom_range(0, 3));
        lba  = LBA_W'({$urandom(), $urandom()});
      end
      all = (op == OP_INVAL) ? ($urandom_range(0, 11) == 0) : 1'($urandom_range(0, 1));
      send_word(op, disk, lba, all);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
design/slc_pkg.sv
design/slc_if.sv
design/slc_cell.sv
design/slc_chain.sv
design/sector_cache_lru_tags.sv
design/slc_chk.sv
tb/slc_checker.sv
tb/tb.sv
